@@ rtl/core/kht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kht_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int FRAME_MAX  = 64;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	typedef enum logic {
		CMD_HOLD  = 1'b0,
		CMD_COUNT = 1'b1
	} kht_cmd_t;

	typedef struct packed {
		kht_cmd_t    command;
		logic [63:0] device_address;
		logic [31:0] frame_key;
		logic        is_query;
		logic [7:0]  endpoint;
		logic [15:0] cluster_id;
		logic [7:0]  frame_length;
		logic [31:0] now_time;
	} kht_in_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] slot_used;
		logic [4:0] held_count;
	} kht_out_t;

	// one slot as stored in RAM
	typedef struct packed {
		logic [63:0] device;
		logic [31:0] key;
		logic [31:0] birth_time;
		logic [31:0] record;
	} kht_entry_t;

	localparam int ENTRY_W = $bits(kht_entry_t);

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
		logic [IDX_W-1:0] old_idx;
		logic [CNT_W-1:0] count;
	} kht_scan_t;

endpackage
`default_nettype wire

@@ rtl/core/kht_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface kht_in_if import kht_pkg::*; ();
	logic    valid;
	logic    ready;
	kht_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kht_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface kht_out_if import kht_pkg::*; ();
	logic     valid;
	logic     ready;
	kht_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

@@ rtl/core/kht_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kht_scan import kht_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             ent_vld,
	input  wire logic [IDX_W-1:0] ent_idx,
	input  wire logic             ent_used,
	input  wire kht_entry_t       ent,
	input  wire logic [63:0]      device_address,
	input  wire logic [31:0]      frame_key,
	input  wire logic [31:0]      now_time,
	output kht_scan_t             res
);
	kht_scan_t   res_q;
	logic [31:0] best_age_q;
	logic [31:0] age;
	logic        dev_match;
	logic        key_match;

	assign age       = now_time - ent.birth_time;
	assign dev_match = ent_used && (ent.device == device_address);
	assign key_match = dev_match && (ent.key == frame_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q      <= '0;
			best_age_q <= '0;
		end else if (start) begin
			res_q      <= '0;
			best_age_q <= '0;
		end else if (ent_vld) begin
			if (key_match && !res_q.hit) begin
				res_q.hit     <= 1'b1;
				res_q.hit_idx <= ent_idx;
			end
			if (!ent_used && !res_q.free) begin
				res_q.free     <= 1'b1;
				res_q.free_idx <= ent_idx;
			end
			if (dev_match) begin
				res_q.count <= res_q.count + CNT_W'(1);
			end
			// strict greater keeps the lowest index on ties
			if (ent_idx == '0 || age > best_age_q) begin
				res_q.old_idx <= ent_idx;
				best_age_q    <= age;
			end
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire

@@ rtl/core/keyed_hold_table_oldest_evict_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Hold table for frames bound to sleeping devices: SLOT_COUNT slots kept in a
// single-port-read RAM, with used marks in flops cleared by reset. Each beat
// (hold or count) reads every slot in turn, one per cycle, collecting the
// matching slot, first free slot, oldest slot and device count; an accepted
// hold then writes the chosen slot back. A new beat is accepted only while
// idle, not during a sweep. A finished result sits in an output register, so
// the next beat can be accepted while it waits. Rejected holds leave the table
// unchanged.
module keyed_hold_table_oldest_evict_top import kht_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	kht_in_if.sink    in_ch,
	kht_out_if.source out_ch
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DONE
	} state_t;

	state_t            state_q;
	kht_in_t           item_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              ent_vld_s1;
	logic [IDX_W-1:0]  ent_idx_s1;
	logic [SLOT_COUNT-1:0] used_q;
	logic              out_vld_q;
	kht_out_t          out_q;

	kht_entry_t        rd_ent;
	kht_entry_t        wr_ent;
	kht_scan_t         scan;
	logic              len_ok;
	logic              do_write;
	logic              out_free;
	logic              wr_en;
	logic [IDX_W-1:0]  sel_idx;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;

	assign len_ok   = (item_q.frame_length <= 8'(FRAME_MAX))
		&& (item_q.is_query || item_q.frame_length != 8'd0);
	assign do_write = (item_q.command == CMD_HOLD) && len_ok;
	assign out_free = !out_vld_q || out_ch.ready;
	assign wr_en    = (state_q == S_DONE) && out_free && do_write;
	assign sel_idx  = scan.hit ? scan.hit_idx : (scan.free ? scan.free_idx : scan.old_idx);

	assign wr_ent.device     = item_q.device_address;
	assign wr_ent.key        = item_q.frame_key;
	assign wr_ent.birth_time = item_q.now_time;
	assign wr_ent.record     = {item_q.endpoint, item_q.cluster_id, item_q.frame_length};

	kht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(sel_idx),
		.wr_data(wr_ent),
		.rd_addr(rd_idx_q),
		.rd_data(rd_ent)
	);

	kht_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_ch.valid && in_ch.ready),
		.ent_vld       (ent_vld_s1),
		.ent_idx       (ent_idx_s1),
		.ent_used      (used_q[ent_idx_s1]),
		.ent           (rd_ent),
		.device_address(item_q.device_address),
		.frame_key     (item_q.frame_key),
		.now_time      (item_q.now_time),
		.res           (scan)
	);

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_q <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_idx_q   <= '0;
			ent_vld_s1 <= 1'b0;
			ent_idx_s1 <= '0;
			used_q     <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			ent_vld_s1 <= (state_q == S_SCAN);
			ent_idx_s1 <= rd_idx_q;
			if (state_q == S_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (in_ch.valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == IDX_W'(SLOT_COUNT - 1)) begin
						state_q <= S_LAST;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						if (item_q.command == CMD_COUNT) begin
							out_q.accepted   <= 1'b1;
							out_q.slot_used  <= '0;
							out_q.held_count <= 5'(scan.count);
						end else begin
							out_q.accepted   <= do_write;
							out_q.slot_used  <= do_write ? 4'(sel_idx) : 4'd0;
							out_q.held_count <= '0;
						end
						if (do_write) begin
							used_q[sel_idx] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import kht_pkg::*;

	class hold_table_checker;
		bit          occupied[SLOT_COUNT];
		logic [63:0] owner[SLOT_COUNT];
		logic [31:0] purpose[SLOT_COUNT];
		logic [31:0] stamp[SLOT_COUNT];
		kht_out_t    expected_replies[$];
		int          fails;

		function new();
			foreach (occupied[i]) occupied[i] = 1'b0;
			fails = 0;
		endfunction

		// wrap-safe oldest wins, lowest index on ties
		function int pick_slot(kht_in_t c);
			int pick;
			logic [31:0] best_age;
			logic [31:0] age;
			pick = -1;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (pick < 0 && occupied[i] && owner[i] == c.device_address &&
				    purpose[i] == c.frame_key)
					pick = i;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (pick < 0 && !occupied[i])
					pick = i;
			if (pick < 0) begin
				pick = 0;
				best_age = c.now_time - stamp[0];
				for (int i = 1; i < SLOT_COUNT; i++) begin
					age = c.now_time - stamp[i];
					if (age > best_age) begin
						pick = i;
						best_age = age;
					end
				end
			end
			return pick;
		endfunction

		function kht_out_t predict_reply(kht_in_t c);
			kht_out_t r;
			int n;
			int s;
			r = '0;
			if (c.command == CMD_COUNT) begin
				n = 0;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (occupied[i] && owner[i] == c.device_address)
						n++;
				r.accepted = 1'b1;
				r.held_count = n[4:0];
				return r;
			end
			if (c.frame_length > FRAME_MAX)
				return r;
			if (!c.is_query && c.frame_length == 8'd0)
				return r;
			s = pick_slot(c);
			occupied[s] = 1'b1;
			owner[s] = c.device_address;
			purpose[s] = c.frame_key;
			stamp[s] = c.now_time;
			r.accepted = 1'b1;
			r.slot_used = s[3:0];
			return r;
		endfunction

		function void note_command(kht_in_t c);
			expected_replies.push_back(predict_reply(c));
		endfunction

		function void check_reply(kht_out_t got);
			kht_out_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, got accepted %0b slot %0d count %0d",
				         $time, got.accepted, got.slot_used, got.held_count);
				fails++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.accepted !== want.accepted) begin
				$display("%0t: accepted expected %0b, got %0b", $time, want.accepted, got.accepted);
				fails++;
			end
			if (got.slot_used !== want.slot_used) begin
				$display("%0t: slot_used expected %0d, got %0d", $time, want.slot_used, got.slot_used);
				fails++;
			end
			if (got.held_count !== want.held_count) begin
				$display("%0t: held_count expected %0d, got %0d", $time, want.held_count,
				         got.held_count);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kht_in_if  in_ch();
	kht_out_if out_ch();

	keyed_hold_table_oldest_evict_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	hold_table_checker sb = new();

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int hold_off_request = 0;

	logic [63:0] dev_pool[5];
	logic [31:0] key_pool[6];
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: ready changes at the falling edge, long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request > 0) begin
				hold_left = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else
				out_ch.ready = ($urandom_range(99) >= out_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_reply(out_ch.data);
	end

	task automatic send_command(input kht_in_t c);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = c;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_command(c);
		@(negedge clk);
	endtask

	function automatic kht_in_t make_hold(logic [63:0] dev, logic [31:0] key, logic query,
	                                      logic [7:0] len, logic [31:0] now);
		kht_in_t c;
		c.command = CMD_HOLD;
		c.device_address = dev;
		c.frame_key = key;
		c.is_query = query;
		c.endpoint = 8'($urandom);
		c.cluster_id = 16'($urandom);
		c.frame_length = len;
		c.now_time = now;
		return c;
	endfunction

	function automatic kht_in_t make_count(logic [63:0] dev);
		kht_in_t c;
		c = '0;
		c.command = CMD_COUNT;
		c.device_address = dev;
		c.frame_key = $urandom;
		c.is_query = 1'($urandom);
		c.endpoint = 8'($urandom);
		c.cluster_id = 16'($urandom);
		c.frame_length = 8'($urandom);
		c.now_time = $urandom;
		return c;
	endfunction

	function automatic kht_in_t random_command();
		kht_in_t c;
		logic [63:0] dev;
		logic [31:0] key;
		logic [7:0] len;
		int pick;
		dev = ($urandom_range(9) == 0) ? {$urandom, $urandom} : dev_pool[$urandom_range(4)];
		if ($urandom_range(99) < 15)
			return make_count(dev);
		key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(5)];
		pick = $urandom_range(99);
		if (pick < 70)
			len = 8'($urandom_range(FRAME_MAX, 1));
		else if (pick < 80)
			len = 8'd0;
		else if (pick < 90)
			len = 8'($urandom_range(255, FRAME_MAX + 1));
		else
			len = ($urandom_range(1)) ? 8'(FRAME_MAX) : 8'd1;
		if ($urandom_range(99) < 3)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(50);
		c = make_hold(dev, key, ($urandom_range(99) < 30), len,
		              ($urandom_range(99) < 5) ? $urandom : clock_ms);
		return c;
	endfunction

	initial begin
		kht_in_t c;
		logic [63:0] ones;
		logic [31:0] t0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		ones = '1;
		t0 = 32'hFFFF_FFF0;
		foreach (dev_pool[i]) dev_pool[i] = {$urandom, $urandom};
		foreach (key_pool[i]) key_pool[i] = $urandom;
		clock_ms = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: rejections, query lengths, replacement, full table, ties, wrap
		send_command(make_count(64'd0));
		send_command(make_hold(ones, 32'hFFFF_FFFF, 1'b0, 8'd0, t0));
		send_command(make_hold(ones, 32'hFFFF_FFFF, 1'b0, 8'(FRAME_MAX + 1), t0));
		send_command(make_hold(ones, 32'hFFFF_FFFF, 1'b1, 8'd255, t0));
		send_command(make_hold(ones, 32'hFFFF_FFFF, 1'b1, 8'd0, t0));
		c = make_hold(ones, 32'hFFFF_FFFF, 1'b1, 8'(FRAME_MAX), t0);
		c.endpoint = 8'hFF;
		c.cluster_id = 16'hFFFF;
		send_command(c);
		for (int i = 1; i < SLOT_COUNT; i++)
			send_command(make_hold(ones, 32'(i), 1'b0, 8'd1, t0 + 32'(i / 2)));
		send_command(make_count(ones));
		c = make_hold(64'd0, 32'd0, 1'b0, 8'd1, t0 + 32'd40);
		c.endpoint = 8'd0;
		c.cluster_id = 16'd0;
		send_command(c);
		c.frame_key = 32'd1;
		send_command(c);
		send_command(make_count(ones));
		send_command(make_count(64'd0));

		// random: idling phases, with one long receiver hold-off early on
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 82; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 82; end
				default: begin in_idle_pct = 16; out_stall_pct = 16; end
			endcase
			for (int n = 0; n < 112; n++) begin
				if (phase == 0 && n == 30)
					hold_off_request = 300;
				send_command(random_command());
			end
		end
		in_ch.valid = 1'b0;
		out_stall_pct = 0;

		while (sb.expected_replies.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/kht_pkg.sv
rtl/core/kht_in_if.sv
rtl/core/kht_out_if.sv
rtl/core/kht_ram.sv
rtl/core/kht_scan.sv
rtl/core/keyed_hold_table_oldest_evict_top.sv
verif/testbench.sv
